// ----- rtl/mail_headline_detector_top_assert.svh -----
// Assertion macros for the mail headline detector.
`ifndef MAIL_HEADLINE_DETECTOR_TOP_ASSERT_SVH
`define MAIL_HEADLINE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MHD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mail headline detector check failed");

// Next-cycle implication, checked out of reset.
`define MHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mail headline detector check failed");

`endif

// ----- rtl/mhd_pkg.sv -----
// Package for the mail headline detector: types, codes and date templates.
`timescale 1ns / 1ps
package mhd_pkg;

    typedef enum logic [7:0] {
        PH_PREFIX = 8'b0000_0001,
        PH_LEAD   = 8'b0000_0010,
        PH_SENDER = 8'b0000_0100,
        PH_GAP    = 8'b0000_1000,
        PH_DATE   = 8'b0001_0000,
        PH_TTY    = 8'b0010_0000,
        PH_TTYGAP = 8'b0100_0000,
        PH_REJECT = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        REASON_OK        = 2'd0,
        REASON_NO_PREFIX = 2'd1,
        REASON_MISSING   = 2'd2,
        REASON_BAD_DATE  = 2'd3
    } t_reason;

    localparam logic [2:0] FORM_NONE = 3'd0;

    typedef enum logic [2:0] {
        CL_UPPER,
        CL_LOWER,
        CL_DIGIT,
        CL_DIGSP,
        CL_SPACE,
        CL_COLON,
        CL_NONE
    } t_cls;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  prefix_cnt;
        logic        in_quote;
        logic [1:0]  tty_cnt;
        logic [4:0]  date_len;
        logic [3:0]  alive;
        logic        ended;
    } t_mhd_state;

    typedef struct packed {
        logic       is_header;
        t_reason    reason;
        logic [2:0] date_form;
        logic       had_tty;
    } t_mhd_result;

    localparam t_mhd_state STATE_RESET = '{
        phase:      PH_PREFIX,
        prefix_cnt: 3'd0,
        in_quote:   1'b0,
        tty_cnt:    2'd0,
        date_len:   5'd0,
        alive:      4'hF,
        ended:      1'b0
    };

    localparam int          NUM_TMPL   = 4;
    localparam logic [2:0]  PREFIX_LEN = 3'd5;
    localparam logic [4:0]  DATE_SAT   = 5'd31;
    localparam logic [4:0]  TMPL_LEN [NUM_TMPL] = '{5'd24, 5'd28, 5'd25, 5'd21};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // "From " one character at a time
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    // "tty"
    function automatic logic [7:0] tty_char(input logic [1:0] idx);
        return (idx == 2'd2) ? 8'h79 : 8'h74;
    endfunction

    // Character class of template t at position p; CL_NONE past its end.
    function automatic t_cls tmpl_class(input logic [1:0] t, input logic [4:0] p);
        t_cls k;
        k = CL_NONE;
        if (p < 5'd16) begin
            unique case (p)
                5'd0, 5'd4:                         k = CL_UPPER;
                5'd1, 5'd2, 5'd5, 5'd6:             k = CL_LOWER;
                5'd3, 5'd7, 5'd10:                  k = CL_SPACE;
                5'd8:                               k = CL_DIGSP;
                5'd13:                              k = CL_COLON;
                default:                            k = CL_DIGIT;
            endcase
        end else begin
            unique case (t)
                2'd0: begin
                    // ":00 0000"
                    if (p == 5'd16)                     k = CL_COLON;
                    else if (p == 5'd19)                k = CL_SPACE;
                    else if (p < 5'd24)                 k = CL_DIGIT;
                end
                2'd1: begin
                    // ":00 AAA 0000"
                    if (p == 5'd16)                     k = CL_COLON;
                    else if (p == 5'd19 || p == 5'd23)  k = CL_SPACE;
                    else if (p >= 5'd20 && p <= 5'd22)  k = CL_UPPER;
                    else if (p < 5'd28)                 k = CL_DIGIT;
                end
                2'd2: begin
                    // " AAA 0000"
                    if (p == 5'd16 || p == 5'd20)       k = CL_SPACE;
                    else if (p <= 5'd19)                k = CL_UPPER;
                    else if (p < 5'd25)                 k = CL_DIGIT;
                end
                default: begin
                    // " 0000"
                    if (p == 5'd16)                     k = CL_SPACE;
                    else if (p < 5'd21)                 k = CL_DIGIT;
                end
            endcase
        end
        return k;
    endfunction

    function automatic logic class_ok(input t_cls k, input logic [7:0] c);
        logic ok;
        unique case (k)
            CL_UPPER: ok = (c >= 8'h41) && (c <= 8'h5A);
            CL_LOWER: ok = (c >= 8'h61) && (c <= 8'h7A);
            CL_DIGIT: ok = (c >= 8'h30) && (c <= 8'h39);
            CL_DIGSP: ok = (c == CH_SPACE) || ((c >= 8'h30) && (c <= 8'h39));
            CL_SPACE: ok = (c == CH_SPACE);
            CL_COLON: ok = (c == CH_COLON);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Per-template match of byte c at date position p
    function automatic logic [3:0] tmpl_match(input logic [4:0] p, input logic [7:0] c);
        logic [3:0] m;
        for (int i = 0; i < NUM_TMPL; i++) begin
            m[i] = class_ok(tmpl_class(2'(i), p), c);
        end
        return m;
    endfunction

endpackage

// ----- rtl/mhd_step.sv -----
// Per-byte update of the headline scanner state and end-of-line verdict.
`timescale 1ns / 1ps
module mhd_step
    import mhd_pkg::*;
(
    input  t_mhd_state  i_state,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    output t_mhd_state  o_state,
    output t_mhd_result o_result
);

    t_mhd_state  s;
    t_mhd_result res;
    logic        do_date;
    logic        found;
    logic [4:0]  p;

    always_comb begin
        s       = i_state;
        res     = '{is_header: 1'b0, reason: REASON_OK, date_form: FORM_NONE, had_tty: 1'b0};
        do_date = 1'b0;
        found   = 1'b0;
        p       = 5'd0;

        if (!s.ended) begin
            if (i_char == CH_NUL) begin
                s.ended = 1'b1;
            end else begin
                unique case (s.phase)
                    PH_PREFIX: begin
                        if (s.prefix_cnt < PREFIX_LEN && i_char == prefix_char(s.prefix_cnt)) begin
                            s.prefix_cnt = s.prefix_cnt + 3'd1;
                            if (s.prefix_cnt == PREFIX_LEN) begin
                                s.phase = PH_LEAD;
                            end
                        end else begin
                            s.phase = PH_REJECT;
                        end
                    end
                    PH_LEAD: begin
                        if (!is_blank(i_char)) begin
                            s.phase    = PH_SENDER;
                            s.in_quote = (i_char == CH_QUOTE);
                        end
                    end
                    PH_SENDER, PH_TTY: begin
                        // quoted stretches keep blanks inside the word
                        if (s.in_quote) begin
                            if (i_char == CH_QUOTE) begin
                                s.in_quote = 1'b0;
                            end
                        end else if (is_blank(i_char)) begin
                            s.phase = (s.phase == PH_SENDER) ? PH_GAP : PH_TTYGAP;
                        end else if (i_char == CH_QUOTE) begin
                            s.in_quote = 1'b1;
                        end
                    end
                    PH_GAP, PH_TTYGAP: begin
                        if (!is_blank(i_char)) begin
                            s.phase    = PH_DATE;
                            s.date_len = 5'd0;
                            s.alive    = 4'hF;
                            do_date    = 1'b1;
                        end
                    end
                    PH_DATE: begin
                        do_date = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_date) begin
            p       = s.date_len;
            s.alive = s.alive & tmpl_match(p, i_char);
            if (p < 5'd3 && s.tty_cnt == p[1:0] && i_char == tty_char(p[1:0])) begin
                s.tty_cnt = s.tty_cnt + 2'd1;
                if (s.tty_cnt == 2'd3) begin
                    s.phase    = PH_TTY;
                    s.in_quote = 1'b0;
                end
            end
            s.date_len = (p < DATE_SAT) ? p + 5'd1 : DATE_SAT;
        end

        if (i_last) begin
            res.had_tty = (s.tty_cnt == 2'd3);
            if (s.phase == PH_PREFIX || s.phase == PH_REJECT) begin
                res.reason = REASON_NO_PREFIX;
            end else if (s.phase != PH_DATE) begin
                res.reason = REASON_MISSING;
            end else begin
                res.reason = REASON_BAD_DATE;
                for (int i = 0; i < NUM_TMPL; i++) begin
                    if (!found && s.alive[i] && s.date_len == TMPL_LEN[i]) begin
                        found         = 1'b1;
                        res.is_header = 1'b1;
                        res.reason    = REASON_OK;
                        res.date_form = 3'(i + 1);
                    end
                end
            end
            s = STATE_RESET;
        end
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

// ----- rtl/mail_headline_detector_top.sv -----
// Top level of the mail headline detector.
`timescale 1ns / 1ps
`include "mail_headline_detector_top_assert.svh"
// Mail headline detector
// ----------------------
// Input channel (i_in_valid / o_in_ready): one byte of a text line per
// transaction, i_char_in, with i_line_end set on the line's last byte. A zero
// byte ends the string; bytes after it up to the line end are ignored.
// Output channel (o_out_valid / i_out_ready): one transaction per line, issued
// for the byte that carried i_line_end: o_is_header, o_reason, o_date_form
// and o_had_tty. No other byte produces an output.
// Throughput: one byte per cycle, sustained, as long as the receiver keeps up.
// The verdict is registered: the last byte goes into the input register, then
// the per-byte scan writes its verdict into the output register.
// A stalled receiver holds the output register; the pipeline keeps taking
// bytes that do not end a line, and a line-ending byte waits in the input
// register until the output register frees up, backpressuring o_in_ready.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// scanner to the start of a line.
module mail_headline_detector_top
    import mhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_is_header,
    output logic [1:0] o_reason,
    output logic [2:0] o_date_form,
    output logic       o_had_tty
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;

    // scanner state and output register
    t_mhd_state  r_state;
    t_mhd_state  n_state;
    t_mhd_result n_result;
    t_mhd_result r_result;
    logic        r_out_valid;

    logic        s1_fire;
    logic        in_fire;

    // A non-final byte only touches state; a final byte needs a free output slot.
    assign s1_fire    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    mhd_step u_step (
        .i_state  (r_state),
        .i_char   (r_char),
        .i_last   (r_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_char <= i_char_in;
            r_last <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_last) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_header = r_result.is_header;
    assign o_reason    = r_result.reason;
    assign o_date_form = r_result.date_form;
    assign o_had_tty   = r_result.had_tty;

    // A headline always carries a form and reason ok; anything else carries no form.
    `MHD_ASSERT_NOW(a_hdr_form, o_out_valid && o_is_header, o_reason == REASON_OK && o_date_form != FORM_NONE)
    `MHD_ASSERT_NOW(a_fail_noform, o_out_valid && !o_is_header, o_date_form == FORM_NONE && o_reason != REASON_OK)
    // Line end always lands a verdict and rearms the scanner.
    `MHD_ASSERT_NEXT(a_last_out, s1_fire && r_last, r_out_valid && r_state.phase == PH_PREFIX && r_state.prefix_cnt == 3'd0 && !r_state.ended)

endmodule

// ----- dv/mhd_checker.sv -----
// Checker for the mail headline detector: scans accepted bytes and compares line verdicts.
`timescale 1ns / 1ps
module mhd_checker
    import mhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_is_header,
    input  logic [1:0] i_reason,
    input  logic [2:0] i_date_form,
    input  logic       i_had_tty,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct {
        logic       hdr;
        t_reason    why;
        logic [2:0] form;
        logic       tty;
    } t_verdict;

    localparam logic [39:0] FROM_TXT = "From ";
    localparam logic [23:0] TTY_TXT  = "tty";

    t_verdict   verdicts_due[$];

    // line scanner state
    t_phase     ph;
    logic [2:0] pre_cnt;
    logic       quoted;
    logic [1:0] tty_cnt;
    logic [4:0] dlen;
    logic [3:0] alive;
    logic       str_done;

    int         n_bad = 0;

    // A upper, a lower, 0 digit, O digit or space, anything else literal
    function automatic string date_shape(input int t);
        string s;
        case (t)
            0:       s = "Aaa Aaa O0 00:00:00 0000";
            1:       s = "Aaa Aaa O0 00:00:00 AAA 0000";
            2:       s = "Aaa Aaa O0 00:00 AAA 0000";
            default: s = "Aaa Aaa O0 00:00 0000";
        endcase
        return s;
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic fits(input logic [7:0] k, input logic [7:0] c);
        logic ok;
        case (k)
            "A":     ok = (c >= "A") && (c <= "Z");
            "a":     ok = (c >= "a") && (c <= "z");
            "0":     ok = (c >= "0") && (c <= "9");
            "O":     ok = (c == CH_SPACE) || ((c >= "0") && (c <= "9"));
            default: ok = (c == k);
        endcase
        return ok;
    endfunction

    task automatic clear_scan();
        ph       = PH_PREFIX;
        pre_cnt  = 3'd0;
        quoted   = 1'b0;
        tty_cnt  = 2'd0;
        dlen     = 5'd0;
        alive    = 4'hF;
        str_done = 1'b0;
    endtask

    task automatic date_byte(input logic [7:0] c);
        string s;
        for (int i = 0; i < 4; i++) begin
            s = date_shape(i);
            if (dlen >= s.len() || !fits(s[dlen], c))
                alive[i] = 1'b0;
        end
        // first three date bytes may spell a tty word
        if (dlen < 5'd3 && tty_cnt == dlen[1:0] && c == TTY_TXT[8*(2-tty_cnt) +: 8]) begin
            tty_cnt = tty_cnt + 2'd1;
            if (tty_cnt == 2'd3) begin
                ph     = PH_TTY;
                quoted = 1'b0;
            end
        end
        dlen = (dlen < 5'd31) ? dlen + 5'd1 : 5'd31;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic last);
        t_verdict v;
        string    shp;
        if (!str_done) begin
            if (c == CH_NUL) begin
                str_done = 1'b1;
            end else begin
                case (ph)
                    PH_PREFIX: begin
                        if (pre_cnt < 3'd5 && c == FROM_TXT[8*(4-pre_cnt) +: 8]) begin
                            pre_cnt = pre_cnt + 3'd1;
                            if (pre_cnt == 3'd5)
                                ph = PH_LEAD;
                        end else begin
                            ph = PH_REJECT;
                        end
                    end
                    PH_LEAD: begin
                        if (!blank_byte(c)) begin
                            ph     = PH_SENDER;
                            quoted = (c == CH_QUOTE);
                        end
                    end
                    PH_SENDER, PH_TTY: begin
                        if (quoted) begin
                            if (c == CH_QUOTE)
                                quoted = 1'b0;
                        end else if (blank_byte(c)) begin
                            ph = (ph == PH_SENDER) ? PH_GAP : PH_TTYGAP;
                        end else if (c == CH_QUOTE) begin
                            quoted = 1'b1;
                        end
                    end
                    PH_GAP, PH_TTYGAP: begin
                        if (!blank_byte(c)) begin
                            ph    = PH_DATE;
                            dlen  = 5'd0;
                            alive = 4'hF;
                            date_byte(c);
                        end
                    end
                    PH_DATE: date_byte(c);
                    default: ;
                endcase
            end
        end

        if (last) begin
            v.hdr  = 1'b0;
            v.form = FORM_NONE;
            v.tty  = (tty_cnt == 2'd3);
            if (ph == PH_PREFIX || ph == PH_REJECT) begin
                v.why = REASON_NO_PREFIX;
            end else if (ph != PH_DATE) begin
                v.why = REASON_MISSING;
            end else begin
                v.why = REASON_BAD_DATE;
                for (int i = 0; i < 4; i++) begin
                    shp = date_shape(i);
                    if (!v.hdr && alive[i] && dlen == shp.len()) begin
                        v.hdr  = 1'b1;
                        v.why  = REASON_OK;
                        v.form = 3'(i + 1);
                    end
                end
            end
            verdicts_due.push_back(v);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        logic     bad;
        if (!i_rst_n) begin
            clear_scan();
            verdicts_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                scan_byte(i_char_in, i_line_end);
            if (i_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] verdict with no line pending: hdr=%0d reason=%0d form=%0d tty=%0d",
                                 $time, i_is_header, i_reason, i_date_form, i_had_tty);
                end else begin
                    want = verdicts_due.pop_front();
                    bad  = (i_is_header !== want.hdr) || (i_reason !== want.why) ||
                           (i_date_form !== want.form) || (i_had_tty !== want.tty);
                    if (bad) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("[%0t] verdict mismatch: exp hdr=%0d reason=%0d form=%0d tty=%0d, got hdr=%0d reason=%0d form=%0d tty=%0d",
                                     $time, want.hdr, want.why, want.form, want.tty,
                                     i_is_header, i_reason, i_date_form, i_had_tty);
                    end
                end
            end
        end
        o_fail_count <= n_bad;
        o_pending    <= verdicts_due.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the mail headline detector: line stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
    import mhd_pkg::*;

    // Receiver hold-off used once to back the block up into its input.
    localparam int HOLD_CYCLES = 400;
    // Cycles with no transaction on either channel before the run is declared hung.
    // Far above the hold-off plus the longest random gap on either side.
    localparam int STALL_LIMIT = 4000;
    // Stop starting random lines once this many bytes have gone in.
    localparam int BYTE_GOAL   = 1900;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_in;
    logic       line_end;
    logic       out_valid;
    logic       out_ready;
    logic       is_header;
    logic [1:0] reason;
    logic [2:0] date_form;
    logic       had_tty;

    int         n_fail;
    int         n_pending;

    // Bytes of the line being built, sent as a burst of input transactions.
    logic [7:0] line_buf[$];
    int         n_lines = 0;
    int         n_bytes = 0;
    int         idle_cycles = 0;

    // Random idling on each side; both drop to zero for a calm stretch.
    bit         tx_idles = 1'b1;
    bit         rx_idles = 1'b1;
    // Set by the stimulus, picked up by the receiver for one long hold-off.
    bit         hold_req = 1'b0;

    mail_headline_detector_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_char_in   (char_in),
        .i_line_end  (line_end),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_is_header (is_header),
        .o_reason    (reason),
        .o_date_form (date_form),
        .o_had_tty   (had_tty)
    );

    mhd_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_char_in    (char_in),
        .i_line_end   (line_end),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_is_header  (is_header),
        .i_reason     (reason),
        .i_date_form  (date_form),
        .i_had_tty    (had_tty),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random ready, except for the one long hold-off on request.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= rx_idles ? ($urandom_range(99) >= 18) : 1'b1;
            end
        end
    end

    // Watchdog: ends the run once the idle count on both channels reaches STALL_LIMIT.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("mail_headline_detector_top verification failed");
        $finish;
    end

    // Same letter code as the date templates, plus b for a random blank.
    function automatic string form_shape(input int t);
        string s;
        case (t)
            0:       s = "Aaa Aaa O0 00:00:00 0000";
            1:       s = "Aaa Aaa O0 00:00:00 AAA 0000";
            2:       s = "Aaa Aaa O0 00:00 AAA 0000";
            default: s = "Aaa Aaa O0 00:00 0000";
        endcase
        return s;
    endfunction

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Append random bytes that follow a letter-code shape.
    task automatic put_shaped(input string shape);
        logic [7:0] k;
        logic [7:0] b;
        for (int i = 0; i < shape.len(); i++) begin
            k = shape[i];
            case (k)
                "A":     b = 8'h41 + 8'($urandom_range(25));     // A..Z
                "a":     b = 8'h61 + 8'($urandom_range(25));     // a..z
                "0":     b = 8'h30 + 8'($urandom_range(9));      // 0..9
                "O":     b = $urandom_range(1) ? CH_SPACE : 8'h30 + 8'($urandom_range(9));
                "b":     b = $urandom_range(1) ? CH_TAB : CH_SPACE;
                default: b = k;
            endcase
            line_buf.push_back(b);
        end
    endtask

    // One input transaction; valid stays up from offer to acceptance.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (tx_idles && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        line_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        n_bytes += line_buf.size();
        n_lines++;
        line_buf.delete();
    endtask

    // Mostly well-formed headlines with random content, some corrupted;
    // the rest broken prefixes, truncated structure and raw noise.
    task automatic make_random_line();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 65) begin
            put("From ");
            repeat ($urandom_range(2)) put_shaped("b");
            if ($urandom_range(4) == 0) begin
                // quoted sender with a blank inside
                put("\"");
                put_shaped("aabaaa");
                put("\"");
            end else begin
                repeat ($urandom_range(1, 6)) put_shaped("a");
            end
            repeat ($urandom_range(1, 2)) put_shaped("b");
            if ($urandom_range(2) == 0) begin
                put("tty");
                repeat ($urandom_range(3)) put_shaped("0");
                repeat ($urandom_range(1, 2)) put_shaped("b");
            end
            put_shaped(form_shape($urandom_range(3)));
            case ($urandom_range(9))
                0: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
                1: void'(line_buf.pop_back());
                2: line_buf.push_back(8'($urandom_range(255)));
                3: begin
                    // string cut short by a zero byte, junk after it
                    line_buf[$urandom_range(line_buf.size() - 1)] = CH_NUL;
                    put_shaped("aa");
                end
                default: ;
            endcase
        end else if (kind < 80) begin
            // short or damaged prefix
            put("From ");
            n = $urandom_range(5);
            while (line_buf.size() > n) void'(line_buf.pop_back());
            if (n > 0 && $urandom_range(1))
                line_buf[$urandom_range(n - 1)] = 8'($urandom_range(255));
            if ($urandom_range(1)) begin
                put("a ");
                put_shaped(form_shape($urandom_range(3)));
            end
        end else if (kind < 90) begin
            put("From ");
            put_shaped("aaa");
            case ($urandom_range(4))
                0: ;                                  // sender only
                1: put_shaped("b");                   // sender, blank, no date
                2: begin                              // word that only starts like tty
                    put(" tt");
                    put_shaped("a");
                end
                3: begin                              // tty word, then blanks only
                    put(" tty");
                    put_shaped("0b");
                end
                default: begin                        // quote never closed
                    put(" \"");
                    put_shaped("ab");
                    put_shaped(form_shape(0));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(255)));
        end
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(255)));
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        char_in  <= 8'h00;
        line_end <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed lines ----
        // one of each date form
        put("From alice Mon Jan  1 00:00:00 2024");          send_line();
        put("From bob Tue Feb 29 12:34:56 PST 1999");        send_line();
        put("From carol Wed Mar 10 23:59 EST 2001");         send_line();
        put("From dave Thu Apr 30 09:15 1987");              send_line();
        // tty word skipped, then a good date
        put("From eve tty03 Fri May 05 01:02:03 2000");      send_line();
        // quoted sender holding blanks, extra blanks and tabs around it
        put("From  \t\"j d\" \t Sat Jun  6 06:06:06 2006");  send_line();
        // too short for the prefix, wrong prefix
        put("Fro");                                          send_line();
        put("Xrom a Mon Jan  1 00:00:00 2024");              send_line();
        // prefix only, sender only, sender plus blanks
        put("From ");                                        send_line();
        put("From alice");                                   send_line();
        put("From alice \t ");                               send_line();
        // tty word with nothing after it, or blanks only
        put("From a ttyS1");                                 send_line();
        put("From a ttyp0  ");                               send_line();
        // starts like tty but is not
        put("From a ttx Mon Jan  1 00:00:00 2024");          send_line();
        // one class off, one byte too long, and a date past the length ceiling
        put("From a mon Jan  1 00:00:00 2024");              send_line();
        put("From a Mon Jan  1 00:00:00 20245");             send_line();
        put("From a Mon Jan  1 00:00:00 2024 0123456789 abcdefghij");
        send_line();
        // zero byte: ends the string after a good date, inside the prefix, alone
        put("From a Mon Jan  1 00:00:00 2024");
        line_buf.push_back(CH_NUL);
        put("zz");
        send_line();
        put("Fr");
        line_buf.push_back(CH_NUL);
        put("om a");
        send_line();
        line_buf.push_back(CH_NUL);                          send_line();
        // non-ASCII bytes: alone and inside a date
        line_buf.push_back(8'hFF);                           send_line();
        put("From a Mon Jan  1 0");
        line_buf.push_back(8'hB5);
        put(":00:00 2024");
        send_line();
        // quote opened in the sender and never closed
        put("From \"a b Mon Jan  1 00:00:00 2024");          send_line();

        // ---- random lines ----
        while (n_bytes < BYTE_GOAL) begin
            // a stretch of full-rate traffic on both sides
            tx_idles = !(n_lines >= 35 && n_lines < 50);
            rx_idles = tx_idles;
            // stall the receiver while lines keep coming, so the block backs up
            if (n_lines == 28)
                hold_req = 1'b1;
            make_random_line();
            send_line();
        end
        in_valid <= 1'b0;
        tx_idles = 1'b1;
        rx_idles = 1'b1;

        // let the checker count the last line before waiting on it
        @(posedge clk);
        // drain: every line verdict back, then wait for strays
        while (n_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d lines (%0d bytes): all four date forms, tty words, quoted senders,",
                 n_lines, n_bytes);
        $display("zero bytes, bad prefixes and dates, byte noise, and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (n_fail == 0 && n_pending == 0) begin
            $display("mail_headline_detector_top verification clean");
        end else begin
            $display("mail_headline_detector_top verification failed");
        end
        $finish;
    end

endmodule
